### hw/rtl/dss_pkg.sv
package dss_pkg;

    // defaults for the top-level parameters
    localparam int unsigned MaxRequestsDef = 64;
    localparam int unsigned TrackBitsDef   = 16;

    // fixed widths of the request and result fields
    localparam int unsigned TrkFieldW = 16;
    localparam int unsigned DistW     = 16;
    localparam int unsigned TotW      = 22;
    localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};

    // configuration register map
    localparam int unsigned CfgDataW   = 32;
    localparam int unsigned CfgAddrW   = 3;
    localparam logic        RegStartHead = 1'b0;

    // packed stream widths
    localparam int unsigned InTdataW  = 16;
    localparam int unsigned OutTdataW = 56;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;    // store one request
        logic scan;    // issue one table read of the nearest-track search
        logic commit;  // service the best request found
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;    // read of the last loaded entry is going out now
        logic out_free;     // result register can take a new result
        logic final_round;  // the request found is the last of the batch
    } t_dp_sts;

endpackage

### hw/rtl/dss_ram.sv
module dss_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/dss_ctrl.sv
module dss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    input  dss_pkg::t_dp_sts    i_sts,
    output dss_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_ready
);

    dss_pkg::t_state r_state;
    dss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dss_pkg::S_IDLE: begin
                if (i_in_valid && i_in_last) begin
                    n_state = dss_pkg::S_SCAN;
                end
            end
            dss_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = dss_pkg::S_DRAIN;
                end
            end
            dss_pkg::S_DRAIN: begin
                n_state = dss_pkg::S_EMIT;
            end
            dss_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.final_round ? dss_pkg::S_IDLE : dss_pkg::S_SCAN;
                end
            end
            default: begin
                n_state = dss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dss_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            dss_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            dss_pkg::S_EMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/dss_dp.sv
module dss_dp #(
    parameter int unsigned MAX_REQUESTS = dss_pkg::MaxRequestsDef,
    parameter int unsigned TRACK_BITS   = dss_pkg::TrackBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dss_pkg::t_dp_cmd              i_cmd,
    output dss_pkg::t_dp_sts              o_sts,
    input  logic [dss_pkg::TrkFieldW-1:0] i_track,
    input  logic                          i_last,
    input  logic [dss_pkg::TrkFieldW-1:0] i_start_head,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dss_pkg::TrkFieldW-1:0] o_served_track,
    output logic [dss_pkg::DistW-1:0]     o_seek_distance,
    output logic [dss_pkg::TotW-1:0]      o_total_movement,
    output logic                          o_dropped,
    output logic                          o_final_res
);

    localparam int unsigned IdxW = $clog2(MAX_REQUESTS);
    localparam int unsigned CntW = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned SumW =
        ((TRACK_BITS > dss_pkg::TotW) ? TRACK_BITS : dss_pkg::TotW) + 1;
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_REQUESTS);

    // control state
    logic [CntW-1:0]         r_count;
    logic [CntW-1:0]         r_remaining;
    logic [MAX_REQUESTS-1:0] r_valid;
    logic                    r_ovf;
    logic [IdxW-1:0]         r_addr;
    logic                    r_rd_pend;
    logic [IdxW-1:0]         r_rd_idx;
    logic                    r_found;
    logic                    r_out_valid;

    // payload state
    logic [TRACK_BITS-1:0]       r_head;
    logic [dss_pkg::TotW-1:0]    r_total;
    logic [IdxW-1:0]             r_best_idx;
    logic [TRACK_BITS-1:0]       r_best_d;
    logic [TRACK_BITS-1:0]       r_best_trk;
    logic [dss_pkg::TrkFieldW-1:0] r_out_trk;
    logic [dss_pkg::DistW-1:0]   r_out_dist;
    logic [dss_pkg::TotW-1:0]    r_out_total;
    logic                        r_out_drop;
    logic                        r_out_last;

    logic [TRACK_BITS-1:0]    w_rd_trk;
    logic [TRACK_BITS-1:0]    n_dist;
    logic                     w_better;
    logic                     w_room;
    logic [CntW-1:0]          n_count;
    logic [SumW-1:0]          n_sum;
    logic [dss_pkg::TotW-1:0] n_total;
    logic [CntW-1:0]          w_count_m1;

    dss_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_room),
        .i_waddr (r_count[IdxW-1:0]),
        .i_wdata (TRACK_BITS'(i_track)),
        .i_raddr (r_addr),
        .o_rdata (w_rd_trk)
    );

    assign w_room  = (r_count < CntMax);
    assign n_count = w_room ? (r_count + CntW'(1)) : r_count;

    // distance of the entry just read, and whether it beats the best so far
    assign n_dist   = (w_rd_trk >= r_head) ? (w_rd_trk - r_head) : (r_head - w_rd_trk);
    assign w_better = r_rd_pend && r_valid[r_rd_idx] && (!r_found || (n_dist < r_best_d));

    // saturating running total
    assign n_sum   = SumW'(r_total) + SumW'(r_best_d);
    assign n_total = (n_sum > SumW'(dss_pkg::TotMax)) ? dss_pkg::TotMax
                                                       : n_sum[dss_pkg::TotW-1:0];

    assign w_count_m1        = r_count - CntW'(1);
    assign o_sts.scan_last   = (r_addr == w_count_m1[IdxW-1:0]);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.final_round = (r_remaining == CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_remaining <= '0;
            r_valid     <= '0;
            r_ovf       <= 1'b0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_idx    <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan;
            r_rd_idx  <= r_addr;
            if (w_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.scan) begin
                r_addr <= r_addr + IdxW'(1);
            end
            if (i_cmd.load) begin
                r_count <= n_count;
                if (w_room) begin
                    r_valid[r_count[IdxW-1:0]] <= 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_last) begin
                    r_remaining <= n_count;
                    r_addr      <= '0;
                    r_found     <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_valid[r_best_idx] <= 1'b0;
                r_remaining         <= r_remaining - CntW'(1);
                r_addr              <= '0;
                r_found             <= 1'b0;
                if (o_sts.final_round) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_better) begin
            r_best_idx <= r_rd_idx;
            r_best_d   <= n_dist;
            r_best_trk <= w_rd_trk;
        end
        if (i_cmd.load && i_last) begin
            r_head  <= TRACK_BITS'(i_start_head);
            r_total <= '0;
        end
        if (i_cmd.commit) begin
            r_head      <= r_best_trk;
            r_total     <= n_total;
            r_out_trk   <= dss_pkg::TrkFieldW'(r_best_trk);
            r_out_dist  <= dss_pkg::DistW'(r_best_d);
            r_out_total <= n_total;
            r_out_drop  <= r_ovf;
            r_out_last  <= o_sts.final_round;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_served_track   = r_out_trk;
    assign o_seek_distance  = r_out_dist;
    assign o_total_movement = r_out_total;
    assign o_dropped        = r_out_drop;
    assign o_final_res      = r_out_last;

endmodule

### hw/rtl/disk_sstf_scheduler.sv
// channel      | dir | signals                          | contents
// -------------+-----+----------------------------------+-------------------------------------
// request in   | in  | i_s_axis_tvalid/tready/tdata/tlast | tdata[15:0] track, tlast end_of_batch
// result out   | out | o_m_axis_tvalid/tready/tdata/tlast/tuser | tdata: served_track, seek_distance,
//              |     |                                  | total_movement; tuser dropped;
//              |     |                                  | tlast final_res
// config       | in  | apb psel/penable/pwrite/paddr    | 0x0 start_head
//
// a request that does not end a batch is written to the track table as it is accepted
// a batch of N requests is serviced in N rounds; each round scans the loaded
// entries one per cycle through the single read port of the track table
// new requests are taken again once the last result sits in the output register
// a stalled result holds the search after the round that found the next request
// reset is synchronous and clears valid bits, counters and start_head; no clearing pass
module disk_sstf_scheduler #(
    parameter int unsigned MAX_REQUESTS = dss_pkg::MaxRequestsDef,
    parameter int unsigned TRACK_BITS   = dss_pkg::TrackBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [dss_pkg::InTdataW-1:0]   i_s_axis_tdata,   // [15:0] track
    input  logic                           i_s_axis_tlast,   // end_of_batch
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] served_track, [31:16] seek_distance, [53:32] total_movement, [55:54] zero
    output logic [dss_pkg::OutTdataW-1:0]  o_m_axis_tdata,
    output logic                           o_m_axis_tuser,   // [0] dropped
    output logic                           o_m_axis_tlast,   // final_res
    // configuration port
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [dss_pkg::CfgAddrW-1:0]   i_paddr,
    input  logic [dss_pkg::CfgDataW-1:0]   i_pwdata,
    output logic [dss_pkg::CfgDataW-1:0]   o_prdata,
    output logic                           o_pready
);

    logic [dss_pkg::TrkFieldW-1:0] r_start_head;
    logic                          w_reg_sel;

    dss_pkg::t_dp_cmd w_cmd;
    dss_pkg::t_dp_sts w_sts;

    logic [dss_pkg::TrkFieldW-1:0] w_served_track;
    logic [dss_pkg::DistW-1:0]     w_seek_distance;
    logic [dss_pkg::TotW-1:0]      w_total_movement;

    // register index is the word address; only start_head exists
    assign w_reg_sel = (i_paddr[2] == dss_pkg::RegStartHead);
    assign o_pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_reg_sel) begin
            r_start_head <= i_pwdata[dss_pkg::TrkFieldW-1:0];
        end
    end

    assign o_prdata = w_reg_sel ? dss_pkg::CfgDataW'(r_start_head) : '0;

    // sequencer: load, scan rounds, result hand-off
    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_s_axis_tready)
    );

    // track table, nearest-track search and result register
    dss_dp #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_track          (i_s_axis_tdata[dss_pkg::TrkFieldW-1:0]),
        .i_last           (i_s_axis_tlast),
        .i_start_head     (r_start_head),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_served_track   (w_served_track),
        .o_seek_distance  (w_seek_distance),
        .o_total_movement (w_total_movement),
        .o_dropped        (o_m_axis_tuser),
        .o_final_res      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_total_movement, w_seek_distance, w_served_track};

endmodule
